@@ src/tpvr_pkg.sv @@
// Shared types and constants for the tree parent-vector reroot block.
// No dependencies; used by tpvr_store and tree_parent_vector_reroot.
`default_nettype none

package tpvr_pkg;

    // Default tip capacity; the node store holds 2*MAX_TAXA-1 entries.
    localparam int MAX_TAXA_DEF = 32;

    localparam int TAXA_W  = 6;   // taxa_count register
    localparam int NODE_W  = 7;   // node count, up to 2*63-1
    localparam int IDX_W   = 6;   // node index field
    localparam int LINK_W  = 7;   // signed parent link
    localparam int ACT_W   = 2;
    localparam int STAT_W  = 2;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [TAXA_W-1:0] TAXA_RESET = 6'd32;
    localparam logic [TAXA_W-1:0] TAXA_MIN   = 6'd2;
    localparam logic [LINK_W-1:0] LINK_ROOT  = 7'h7F;   // -1, no parent

    // Word index of the taxa_count register on the configuration port.
    localparam logic REG_TAXA = 1'b0;

    typedef enum logic [ACT_W-1:0] {
        ACT_WRITE  = 2'd0,
        ACT_READ   = 2'd1,
        ACT_REBASE = 2'd2
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_CYCLE = 2'd2
    } t_status;

    // Port enables of the node store.
    typedef struct packed {
        logic we;
        logic re;
    } t_store_ctl;

endpackage

`default_nettype wire

@@ src/tpvr_store.sv @@
// Parent-link store: one write port, one read port, registered read data.
// Depends on tpvr_pkg for link width and the port-enable struct.
`default_nettype none

module tpvr_store #(
    parameter int DEPTH = 2 * tpvr_pkg::MAX_TAXA_DEF - 1,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire                            i_clk,
    input  wire  tpvr_pkg::t_store_ctl     i_ctl,
    input  wire  [AW-1:0]                  i_waddr,
    input  wire  [tpvr_pkg::LINK_W-1:0]    i_wdata,
    input  wire  [AW-1:0]                  i_raddr,
    output logic [tpvr_pkg::LINK_W-1:0]    o_rdata
);

    logic [tpvr_pkg::LINK_W-1:0] mem [DEPTH];
    logic [tpvr_pkg::LINK_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Hold the last read word until the next read.
    always_ff @(posedge i_clk) begin
        if (i_ctl.re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ src/tree_parent_vector_reroot.sv @@
// Top level of the tree parent-vector reroot block: command sequencer and
// configuration port. Depends on tpvr_pkg and tpvr_store.
`default_nettype none

// A binary tree is kept as a table of parent links, one 7-bit signed entry per
// node, with a negative link marking the root. A command is a transfer taken
// when start is high and busy is low; it writes one link, reads one link,
// rebases the tree on a tip, or (unused action code) does nothing. Every
// command gives exactly one result, shown on o_read_parent/o_status for one
// cycle with o_done high; the receiver cannot stall, so it must take the
// result in that cycle. Sequence: write, unused action and out-of-range
// commands finish at the accepting edge (result in the next cycle); a read
// passes through the store's read register and then the result registers.
// A rebase ends after reading the tip's parent when the tip is a root or its
// link is out of range, and after the first walk step when the tip already
// hangs under the root. Otherwise it goes through accept, tip's parent,
// upward walk over the path nodes, link reversal, a scan of all n nodes in
// use for the root's other child, and the final link updates, with
// n = 2*taxa_count-1 (taxa_count clamped); a walk that finds a loop or an
// out-of-range link ends with ST_CYCLE or ST_RANGE. The steps run one after
// another on the store's single read port. After reset the store is cleared
// to "no parent" one entry a cycle, all 2*MAX_TAXA-1 entries, with busy high;
// configuration writes are taken throughout. Write taxa_count only while no command is in progress.
module tree_parent_vector_reroot #(
    parameter int MAX_TAXA = tpvr_pkg::MAX_TAXA_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,

    // command channel
    input  wire                                 start,
    output logic                                busy,
    input  wire         [tpvr_pkg::ACT_W-1:0]   i_action,
    input  wire         [tpvr_pkg::IDX_W-1:0]   i_node_index,
    input  wire  signed [tpvr_pkg::LINK_W-1:0]  i_parent_value,

    // result channel
    output logic                                o_done,
    output logic signed [tpvr_pkg::LINK_W-1:0]  o_read_parent,
    output logic        [tpvr_pkg::STAT_W-1:0]  o_status,

    // configuration port
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire         [tpvr_pkg::PADDR_W-1:0] paddr,
    input  wire         [tpvr_pkg::PDATA_W-1:0] pwdata,
    output logic        [tpvr_pkg::PDATA_W-1:0] prdata,
    output logic                                pready
);

    localparam int DEPTH = 2 * MAX_TAXA - 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int KW    = $clog2(DEPTH + 1);
    localparam int CMPW  = (KW > tpvr_pkg::NODE_W) ? KW : tpvr_pkg::NODE_W;

    typedef enum logic [3:0] {
        S_CLEAR,      // post-reset clearing pass
        S_IDLE,
        S_READ,       // read data for a read command
        S_TIP,        // tip's parent arrives
        S_WALK,       // climb to the root, one link a cycle
        S_REV,        // reverse the links along the path
        S_SCAN,       // find the root's other child
        S_FIX_NB,     // hang the other child on the last path node
        S_FIX_TIP,    // root becomes parent of the tip
        S_FIX_ANC     // root becomes parent of the tip's former parent
    } t_state;

    t_state                          r_state;
    logic [KW-1:0]                   r_k;        // clear / scan counter
    logic [KW-1:0]                   r_kp;       // node whose link is in r_rdata
    logic                            r_scan_v;
    logic [tpvr_pkg::IDX_W-1:0]      r_node;     // new base tip
    logic [tpvr_pkg::IDX_W-1:0]      r_stanc;    // tip's former parent
    logic [tpvr_pkg::IDX_W-1:0]      r_j;
    logic [tpvr_pkg::IDX_W-1:0]      r_i;
    logic [tpvr_pkg::IDX_W-1:0]      r_old;      // old root
    logic [AW-1:0]                   r_oldnb;
    logic                            r_have;
    logic [tpvr_pkg::NODE_W-1:0]     r_cnt;
    logic [tpvr_pkg::TAXA_W-1:0]     r_taxa;
    logic                            r_done;
    logic [tpvr_pkg::LINK_W-1:0]     r_rd;
    logic [tpvr_pkg::STAT_W-1:0]     r_status;

    tpvr_pkg::t_store_ctl            w_ctl;
    logic [AW-1:0]                   w_waddr;
    logic [AW-1:0]                   w_raddr;
    logic [tpvr_pkg::LINK_W-1:0]     w_wdata;
    logic [tpvr_pkg::LINK_W-1:0]     w_rdata;

    logic [tpvr_pkg::TAXA_W-1:0]     w_tips;
    logic [tpvr_pkg::NODE_W-1:0]     w_ncnt;
    logic                            w_accept;
    logic                            w_node_ok;
    logic                            w_act_used;
    logic                            w_rd_neg;
    logic                            w_rd_in;
    logic                            w_cnt_over;
    logic                            w_rd_is_old;
    logic                            w_scan_more;
    logic                            w_cfg_wr;

    // Node count in use: taxa_count clamped to [2, MAX_TAXA], times two minus one.
    always_comb begin
        if (r_taxa < tpvr_pkg::TAXA_MIN) begin
            w_tips = tpvr_pkg::TAXA_MIN;
        end else if (32'(r_taxa) > MAX_TAXA) begin
            w_tips = tpvr_pkg::TAXA_W'(MAX_TAXA);
        end else begin
            w_tips = r_taxa;
        end
    end
    assign w_ncnt = {w_tips, 1'b0} - tpvr_pkg::NODE_W'(1);

    assign w_accept    = start && (r_state == S_IDLE);
    assign w_node_ok   = {1'b0, i_node_index} < w_ncnt;
    // The unused action code skips the index check and reports ok.
    assign w_act_used  = (i_action == tpvr_pkg::ACT_WRITE)
                         || (i_action == tpvr_pkg::ACT_READ)
                         || (i_action == tpvr_pkg::ACT_REBASE);
    assign w_rd_neg    = w_rdata[tpvr_pkg::LINK_W-1];
    assign w_rd_in     = !w_rd_neg && (w_rdata < w_ncnt);
    assign w_cnt_over  = ({1'b0, r_cnt} + 8'd1) > {1'b0, w_ncnt};
    assign w_rd_is_old = (w_rdata == {1'b0, r_old});
    assign w_scan_more = CMPW'(r_k) < CMPW'(w_ncnt);
    assign w_cfg_wr    = psel && penable && pwrite && pready
                         && (paddr[2] == tpvr_pkg::REG_TAXA);

    // Store port control, decoded from the sequencer state.
    always_comb begin
        w_ctl   = '0;
        w_waddr = '0;
        w_wdata = '0;
        w_raddr = '0;
        unique case (r_state)
            S_CLEAR: begin
                w_ctl.we = 1'b1;
                w_waddr  = AW'(r_k);
                w_wdata  = tpvr_pkg::LINK_ROOT;
            end
            S_IDLE: begin
                if (w_accept && w_node_ok) begin
                    if (i_action == tpvr_pkg::ACT_WRITE) begin
                        w_ctl.we = 1'b1;
                        w_waddr  = AW'(i_node_index);
                        w_wdata  = i_parent_value;
                    end else if (i_action == tpvr_pkg::ACT_READ
                                 || i_action == tpvr_pkg::ACT_REBASE) begin
                        w_ctl.re = 1'b1;
                        w_raddr  = AW'(i_node_index);
                    end
                end
            end
            S_TIP: begin
                if (w_rd_in) begin
                    w_ctl.re = 1'b1;
                    w_raddr  = AW'(w_rdata[tpvr_pkg::IDX_W-1:0]);
                end
            end
            S_WALK: begin
                if (!w_cnt_over) begin
                    if (w_rd_in) begin
                        w_ctl.re = 1'b1;
                        w_raddr  = AW'(w_rdata[tpvr_pkg::IDX_W-1:0]);
                    end else if (w_rd_neg && (r_j != r_stanc)) begin
                        w_ctl.re = 1'b1;
                        w_raddr  = AW'(r_stanc);
                    end
                end
            end
            S_REV: begin
                w_ctl.we = 1'b1;
                w_waddr  = AW'(r_i);
                w_wdata  = {1'b0, r_j};
                if (!w_rd_is_old) begin
                    w_ctl.re = 1'b1;
                    w_raddr  = AW'(w_rdata[tpvr_pkg::IDX_W-1:0]);
                end
            end
            S_SCAN: begin
                if (w_scan_more) begin
                    w_ctl.re = 1'b1;
                    w_raddr  = AW'(r_k);
                end
            end
            S_FIX_NB: begin
                w_ctl.we = r_have;
                w_waddr  = r_oldnb;
                w_wdata  = {1'b0, r_j};
            end
            S_FIX_TIP: begin
                w_ctl.we = 1'b1;
                w_waddr  = AW'(r_node);
                w_wdata  = {1'b0, r_old};
            end
            S_FIX_ANC: begin
                w_ctl.we = 1'b1;
                w_waddr  = AW'(r_stanc);
                w_wdata  = {1'b0, r_old};
            end
            default: begin
                w_ctl = '0;
            end
        endcase
    end

    tpvr_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Sequencer, result registers and configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_k      <= '0;
            r_scan_v <= 1'b0;
            r_have   <= 1'b0;
            r_taxa   <= tpvr_pkg::TAXA_RESET;
            r_done   <= 1'b0;
            r_status <= tpvr_pkg::ST_OK;
            r_rd     <= '0;
        end else begin
            r_done <= 1'b0;

            if (w_cfg_wr) begin
                r_taxa <= pwdata[tpvr_pkg::TAXA_W-1:0];
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_k <= r_k + KW'(1);
                    if (r_k == KW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_node <= i_node_index;
                        r_rd   <= '0;
                        if (!w_node_ok && w_act_used) begin
                            r_done   <= 1'b1;
                            r_status <= tpvr_pkg::ST_RANGE;
                        end else begin
                            unique case (i_action)
                                tpvr_pkg::ACT_READ: begin
                                    r_state <= S_READ;
                                end
                                tpvr_pkg::ACT_REBASE: begin
                                    r_state <= S_TIP;
                                end
                                default: begin
                                    // write, or a code with no action
                                    r_done   <= 1'b1;
                                    r_status <= tpvr_pkg::ST_OK;
                                end
                            endcase
                        end
                    end
                end
                S_READ: begin
                    r_done   <= 1'b1;
                    r_status <= tpvr_pkg::ST_OK;
                    r_rd     <= w_rdata;
                    r_state  <= S_IDLE;
                end
                S_TIP: begin
                    priority if (w_rd_neg) begin
                        // tip is the root
                        r_done   <= 1'b1;
                        r_status <= tpvr_pkg::ST_OK;
                        r_state  <= S_IDLE;
                    end else if (!w_rd_in) begin
                        r_done   <= 1'b1;
                        r_status <= tpvr_pkg::ST_RANGE;
                        r_state  <= S_IDLE;
                    end else begin
                        r_stanc <= w_rdata[tpvr_pkg::IDX_W-1:0];
                        r_j     <= w_rdata[tpvr_pkg::IDX_W-1:0];
                        r_cnt   <= '0;
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    // r_rdata holds the parent of r_j
                    priority if (w_cnt_over) begin
                        r_done   <= 1'b1;
                        r_status <= tpvr_pkg::ST_CYCLE;
                        r_state  <= S_IDLE;
                    end else if (w_rd_neg) begin
                        r_old <= r_j;
                        if (r_j == r_stanc) begin
                            // tip already hangs under the root
                            r_done   <= 1'b1;
                            r_status <= tpvr_pkg::ST_OK;
                            r_state  <= S_IDLE;
                        end else begin
                            r_i     <= r_stanc;
                            r_j     <= r_node;
                            r_state <= S_REV;
                        end
                    end else if (!w_rd_in) begin
                        r_done   <= 1'b1;
                        r_status <= tpvr_pkg::ST_RANGE;
                        r_state  <= S_IDLE;
                    end else begin
                        r_j   <= w_rdata[tpvr_pkg::IDX_W-1:0];
                        r_cnt <= r_cnt + tpvr_pkg::NODE_W'(1);
                    end
                end
                S_REV: begin
                    // r_rdata holds the old parent of r_i; the link is rewritten now
                    r_j <= r_i;
                    r_i <= w_rdata[tpvr_pkg::IDX_W-1:0];
                    if (w_rd_is_old) begin
                        r_k      <= '0;
                        r_scan_v <= 1'b0;
                        r_have   <= 1'b0;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // keep the highest-numbered child of the old root, tip excluded
                    if (r_scan_v && w_rd_is_old && (AW'(r_kp) != AW'(r_node))) begin
                        r_oldnb <= AW'(r_kp);
                        r_have  <= 1'b1;
                    end
                    r_scan_v <= w_scan_more;
                    if (w_scan_more) begin
                        r_kp <= r_k;
                        r_k  <= r_k + KW'(1);
                    end else begin
                        r_state <= S_FIX_NB;
                    end
                end
                S_FIX_NB: begin
                    r_state <= S_FIX_TIP;
                end
                S_FIX_TIP: begin
                    r_state <= S_FIX_ANC;
                end
                S_FIX_ANC: begin
                    r_done   <= 1'b1;
                    r_status <= tpvr_pkg::ST_OK;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_read_parent = r_rd;
    assign o_status      = r_status;
    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == tpvr_pkg::REG_TAXA)
                           ? {{(tpvr_pkg::PDATA_W - tpvr_pkg::TAXA_W){1'b0}}, r_taxa}
                           : '0;

endmodule

`default_nettype wire

@@ tb/tpvr_checker.sv @@
// Scoreboard for tree_parent_vector_reroot: follows taxa_count writes and every
// command transfer, predicts each result from its own parent table, compares.
// Depends on tpvr_pkg.
module tpvr_checker (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_start,
    input  wire                                 i_busy,
    input  wire         [tpvr_pkg::ACT_W-1:0]   i_action,
    input  wire         [tpvr_pkg::IDX_W-1:0]   i_node_index,
    input  wire  signed [tpvr_pkg::LINK_W-1:0]  i_parent_value,
    input  wire                                 i_done,
    input  wire  signed [tpvr_pkg::LINK_W-1:0]  i_read_parent,
    input  wire         [tpvr_pkg::STAT_W-1:0]  i_status,
    input  wire                                 i_psel,
    input  wire                                 i_penable,
    input  wire                                 i_pwrite,
    input  wire         [tpvr_pkg::PADDR_W-1:0] i_paddr,
    input  wire         [tpvr_pkg::PDATA_W-1:0] i_pwdata,
    input  wire         [tpvr_pkg::PDATA_W-1:0] i_prdata,
    input  wire                                 i_pready,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_checked
);
    import tpvr_pkg::*;

    localparam int STORE_N = 2 * MAX_TAXA_DEF - 1;
    localparam logic [PADDR_W-1:0] TAXA_ADDR = PADDR_W'(4 * REG_TAXA);

    typedef struct {
        logic signed [LINK_W-1:0] parent;
        t_status                  status;
        logic [ACT_W-1:0]         act;
        logic [IDX_W-1:0]         idx;
        int                       seq;
    } t_outcome;

    logic signed [LINK_W-1:0] link_tbl [0:STORE_N-1];
    logic [TAXA_W-1:0]        taxa_reg;
    t_outcome                 outcome_q [$];
    int                       n_fail;
    int                       n_checked;
    int                       n_seq;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        n_fail       = 0;
        n_checked    = 0;
        n_seq        = 0;
        taxa_reg     = TAXA_RESET;
    end

    function automatic void note_failure(input string msg);
        if (n_fail < 10) $display("MISMATCH: %s", msg);
        n_fail++;
    endfunction

    function automatic int nodes_in_use();
        int t;
        t = taxa_reg;
        if (t < 2) t = 2;
        if (t > MAX_TAXA_DEF) t = MAX_TAXA_DEF;
        return 2 * t - 1;
    endfunction

    // Check the whole upward path before touching the table, then reverse it.
    function automatic t_status rebase_on_tip(input int tip, input int n);
        int anc;
        int top_node;
        int walk;
        int steps;
        int cur;
        int prev;
        int nxt;
        int other;
        int k;
        anc = link_tbl[tip];
        if (anc < 0) return ST_OK;
        if (anc >= n) return ST_RANGE;
        top_node = anc;
        walk     = anc;
        steps    = 0;
        while (walk >= 0) begin
            if (walk >= n) return ST_RANGE;
            steps++;
            if (steps > n) return ST_CYCLE;
            top_node = walk;
            walk     = link_tbl[walk];
        end
        if (anc == top_node) return ST_OK;
        cur  = anc;
        prev = tip;
        while (cur != top_node) begin
            nxt           = link_tbl[cur];
            link_tbl[cur] = LINK_W'(prev);
            prev          = cur;
            cur           = nxt;
        end
        // highest-numbered remaining child of the old root wins
        other = -1;
        for (k = 0; k < n; k++) begin
            if (link_tbl[k] == top_node && k != tip) other = k;
        end
        if (other >= 0) link_tbl[other] = LINK_W'(prev);
        link_tbl[tip] = LINK_W'(top_node);
        link_tbl[anc] = LINK_W'(top_node);
        return ST_OK;
    endfunction

    function automatic t_outcome predict_command(input logic [ACT_W-1:0] act,
                                                 input logic [IDX_W-1:0] idx,
                                                 input logic signed [LINK_W-1:0] pval);
        t_outcome r;
        int       n;
        n        = nodes_in_use();
        r.parent = '0;
        r.status = ST_OK;
        r.act    = act;
        r.idx    = idx;
        r.seq    = n_seq;
        if (act <= ACT_REBASE) begin
            if (int'(idx) >= n) begin
                r.status = ST_RANGE;
            end else begin
                case (act)
                    ACT_WRITE: link_tbl[idx] = pval;
                    ACT_READ:  r.parent = link_tbl[idx];
                    default:   r.status = rebase_on_tip(idx, n);
                endcase
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_outcome want;
        int       k;
        if (!i_rst_n) begin
            for (k = 0; k < STORE_N; k++) link_tbl[k] = LINK_ROOT;
            taxa_reg = TAXA_RESET;
            outcome_q.delete();
        end else begin
            if (i_psel && i_penable && i_pready && i_paddr == TAXA_ADDR) begin
                if (i_pwrite) begin
                    taxa_reg = i_pwdata[TAXA_W-1:0];
                end else if (i_prdata[TAXA_W-1:0] !== taxa_reg) begin
                    note_failure($sformatf("taxa_count read expected %0d, got %0d",
                                           taxa_reg, i_prdata[TAXA_W-1:0]));
                end
            end
            if (i_done) begin
                if (outcome_q.size() == 0) begin
                    note_failure($sformatf("result with nothing outstanding: parent %0d status %0d",
                                           i_read_parent, i_status));
                end else begin
                    want = outcome_q.pop_front();
                    n_checked++;
                    if (i_read_parent !== want.parent)
                        note_failure($sformatf("cmd %0d (action %0d node %0d): read_parent expected %0d, got %0d",
                                               want.seq, want.act, want.idx, want.parent, i_read_parent));
                    if (i_status !== want.status)
                        note_failure($sformatf("cmd %0d (action %0d node %0d): status expected %0d, got %0d",
                                               want.seq, want.act, want.idx, want.status, i_status));
                end
            end
            if (i_start && i_busy === 1'b0) begin
                outcome_q.push_back(predict_command(i_action, i_node_index, i_parent_value));
                n_seq++;
            end
        end
        o_pending    <= outcome_q.size();
        o_fail_count <= n_fail;
        o_checked    <= n_checked;
    end

endmodule

@@ tb/tb.sv @@
// Top of the tree_parent_vector_reroot testbench: clock, reset, command and
// configuration stimulus, verdict. Depends on tpvr_pkg, the block and tpvr_checker.
module tb;
    import tpvr_pkg::*;

    localparam logic [ACT_W-1:0]   ACT_UNUSED   = 2'd3;
    localparam logic [PADDR_W-1:0] TAXA_ADDR    = PADDR_W'(4 * REG_TAXA);
    localparam int                 RANDOM_ITEMS = 600;
    localparam int                 STORE_N      = 2 * MAX_TAXA_DEF - 1;

    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       start        = 1'b0;
    logic                       busy;
    logic [ACT_W-1:0]           action       = '0;
    logic [IDX_W-1:0]           node_index   = '0;
    logic signed [LINK_W-1:0]   parent_value = '0;
    logic                       done;
    logic signed [LINK_W-1:0]   read_parent;
    logic [STAT_W-1:0]          status;
    logic                       psel         = 1'b0;
    logic                       penable      = 1'b0;
    logic                       pwrite       = 1'b0;
    logic [PADDR_W-1:0]         paddr        = '0;
    logic [PDATA_W-1:0]         pwdata       = '0;
    logic [PDATA_W-1:0]         prdata;
    logic                       pready;

    int fail_count;
    int pending;
    int checked;

    // Stimulus bookkeeping
    int idle_pct   = 0;
    int n_cmds     = 0;
    int n_rebases  = 0;
    int n_settings = 0;
    int pool [$];
    int link_plan [0:STORE_N-1];

    // Tip counts to sweep: clamped extremes (0, 1, 63) and mostly small trees
    logic [TAXA_W-1:0] taxa_plan [0:9] = '{6'd2, 6'd0, 6'd63, 6'd5, 6'd9,
                                           6'd1, 6'd32, 6'd12, 6'd3, 6'd20};
    // Sender idle percentage per phase: none, heavy, moderate
    int idle_plan [0:2] = '{0, 80, 32};

    always #5 clk = ~clk;

    tree_parent_vector_reroot u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (action),
        .i_node_index   (node_index),
        .i_parent_value (parent_value),
        .o_done         (done),
        .o_read_parent  (read_parent),
        .o_status       (status),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    tpvr_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_action       (action),
        .i_node_index   (node_index),
        .i_parent_value (parent_value),
        .i_done         (done),
        .i_read_parent  (read_parent),
        .i_status       (status),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_prdata       (prdata),
        .i_pready       (pready),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    // Issue one command transfer. Optionally drop start for a random gap first,
    // then hold start with the new fields until an edge sees busy low.
    // On return start is still high; the next call either reuses it back to
    // back or drops it, so start gets one update per time step.
    task automatic send_cmd(input logic [ACT_W-1:0] act, input int idx, input int pval);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge clk);
        end
        start        <= 1'b1;
        action       <= act;
        node_index   <= IDX_W'(idx);
        parent_value <= LINK_W'(pval);
        do @(posedge clk); while (busy !== 1'b0);
        n_cmds++;
        if (act == ACT_REBASE) n_rebases++;
    endtask

    // Drop start and wait until every command has returned its result and the
    // block reports idle; only then is taxa_count safe to change.
    task automatic wait_idle();
        start <= 1'b0;
        do @(posedge clk); while (pending != 0 || busy !== 1'b0);
    endtask

    // One configuration transfer: setup phase, access phase, then an idle phase
    // so that back-to-back transfers never update psel twice in a step.
    task automatic cfg_access(input logic wr, input logic [TAXA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= TAXA_ADDR;
        pwdata  <= PDATA_W'(val);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    initial begin : stimulus
        int ph;
        int k;
        int j;
        int r;
        int pick;
        int fresh;
        int tips;
        int nodes;
        int dir_end;
        logic [TAXA_W-1:0] setting;

        // Hold reset, then release it; the clearing pass that follows keeps busy
        // high, and the first command simply waits behind it.
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Read back the reset tip count while the store is still clearing.
        cfg_access(1'b0, '0);

        // Directed part with 63 nodes in use.
        send_cmd(ACT_READ,    0,  0);     // untouched entry reads as no parent
        send_cmd(ACT_WRITE,  62, -64);    // most negative link still marks a root
        send_cmd(ACT_READ,   62,  0);
        send_cmd(ACT_WRITE,   0, 63);     // largest link, beyond the last node
        send_cmd(ACT_REBASE,  0,  0);     // tip's own link is out of range
        send_cmd(ACT_WRITE,  63,  5);     // index out of range on each used action
        send_cmd(ACT_READ,   63,  0);
        send_cmd(ACT_REBASE, 63,  0);
        send_cmd(ACT_UNUSED, 63, 63);     // unused action does nothing
        send_cmd(ACT_REBASE, 62,  0);     // tip is itself a root
        send_cmd(ACT_WRITE,   1,  2);     // two nodes pointing at each other
        send_cmd(ACT_WRITE,   2,  1);
        send_cmd(ACT_REBASE,  1,  0);     // walk never reaches a root
        send_cmd(ACT_WRITE,   4,  5);
        send_cmd(ACT_REBASE,  4,  0);     // tip already hangs under the root
        send_cmd(ACT_WRITE,  13, 14);     // root 16 with children 14, 15, 17
        send_cmd(ACT_WRITE,  14, 16);
        send_cmd(ACT_WRITE,  15, 16);
        send_cmd(ACT_WRITE,  17, 16);
        send_cmd(ACT_REBASE, 13,  0);     // several other children: highest moves
        send_cmd(ACT_READ,   17,  0);
        send_cmd(ACT_WRITE,  10, 11);     // root 12 with a single child
        send_cmd(ACT_WRITE,  11, 12);
        send_cmd(ACT_REBASE, 10,  0);     // root has no other child to hang
        send_cmd(ACT_READ,   11,  0);
        dir_end = n_cmds;

        // Random phases: new tip count, a freshly built tree, then mostly
        // rebases on tips and reads with a little noise that breaks the tree.
        ph = 0;
        while (n_cmds < dir_end + RANDOM_ITEMS) begin
            wait_idle();
            setting = (ph % 11 == 10) ? TAXA_W'($urandom_range(63)) : taxa_plan[ph % 10];
            cfg_access(1'b1, setting);
            cfg_access(1'b0, '0);
            n_settings++;
            idle_pct = idle_plan[ph % 3];
            tips = setting;
            if (tips < 2) tips = 2;
            if (tips > MAX_TAXA_DEF) tips = MAX_TAXA_DEF;
            nodes = 2 * tips - 1;

            // Join random pairs of subtrees under new internal nodes.
            pool.delete();
            for (k = 0; k < tips; k++) pool.push_back(k);
            fresh = tips;
            while (pool.size() > 1) begin
                for (j = 0; j < 2; j++) begin
                    pick = $urandom_range(pool.size() - 1);
                    link_plan[pool[pick]] = fresh;
                    pool.delete(pick);
                end
                pool.push_back(fresh);
                fresh++;
            end
            link_plan[fresh - 1] = -1;
            for (k = 0; k < nodes; k++) send_cmd(ACT_WRITE, k, link_plan[k]);

            repeat (30) begin
                r = $urandom_range(99);
                if (r < 55)      send_cmd(ACT_REBASE, $urandom_range(tips - 1), 0);
                else if (r < 62) send_cmd(ACT_REBASE, $urandom_range(63), $urandom_range(127));
                else if (r < 85) send_cmd(ACT_READ, $urandom_range(nodes - 1),
                                          $urandom_range(127));
                else if (r < 90) send_cmd(ACT_READ, $urandom_range(63), 0);
                else if (r < 96) send_cmd(ACT_WRITE, $urandom_range(63), $urandom_range(127));
                else             send_cmd(ACT_UNUSED, $urandom_range(63), $urandom_range(127));
            end
            ph++;
        end

        // Drain: every command returns one result, so a short bounded wait is enough.
        start <= 1'b0;
        @(posedge clk);
        for (k = 0; k < 2000 && (pending != 0 || busy !== 1'b0); k++) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Ran %0d commands (%0d rebases) over %0d tip-count settings,",
                 n_cmds, n_rebases, n_settings);
        $display("sender idling 0/80/32 percent; %0d results compared, %0d still outstanding.",
                 checked, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #10_000_000;
        $display("Simulation limit reached with %0d results outstanding", pending);
        $display("TEST FAILED");
        $finish;
    end

endmodule

@@ files.f @@
src/tpvr_pkg.sv
src/tpvr_store.sv
src/tree_parent_vector_reroot.sv
tb/tpvr_checker.sv
tb/tb.sv
